// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_LAST,
    S_REM_RD,
    S_REM_MV,
    S_FINISH
  } state_t;

  // one finished result
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] min_value;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-priority queue holding keys sorted in ascending order.
// ----------------------------------------------------------------------------
// Each input beat is an insert or a remove-minimum and yields one result beat
// carrying a status, the removed key and the occupancy after the operation.
// Equal keys leave in arrival order. The keys sit in a single array with one
// write and one registered read port, walked by one signed comparator, so
// each visited entry takes a read state and then a compare or move state: an
// insert walks down from the tail past the stored keys greater than the new
// one, a remove shifts all stored keys down by one, and an insert into an
// empty or full queue or a remove from an empty queue finishes at once. The
// input is not ready while an item is in work; a finished result waits in the
// output register, and the block accepts the next input beat while it is
// still waiting.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic signed [spq_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::STAT_W-1:0]        out_status,
  output logic signed [spq_pkg::VAL_W-1:0]  out_min_value,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);
  import spq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;
  logic             slot_free;
  logic             res_valid;
  res_t             res;
  logic             out_valid_r;
  res_t             out_res_r;

  spq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_value  (in_value),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_min_value = out_res_r.min_value;
  assign out_occupancy = out_res_r.occupancy;

endmodule

// ===== rtl/core/spq_mem.sv =====
// ----------------------------------------------------------------------------
// spq_mem
// Key storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [spq_pkg::VAL_W-1:0]   wdata,
  input  logic [AW-1:0]               raddr,
  output logic [spq_pkg::VAL_W-1:0]   rdata
);
  import spq_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer that walks the key store through one shared signed comparator:
// insertion shifts larger keys up from the tail, removal shifts keys down.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic signed [spq_pkg::VAL_W-1:0]  in_value,
  input  logic                              slot_free,
  output logic                              res_valid,
  output spq_pkg::res_t                     res,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [spq_pkg::VAL_W-1:0]         mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [spq_pkg::VAL_W-1:0]         mem_rdata
);
  import spq_pkg::*;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [VAL_W-1:0]  key_r, key_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [VAL_W-1:0]  min_r, min_nxt;

  logic accept;
  logic is_full;
  logic is_empty;
  logic key_le;
  logic at_last;

  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  // shared comparator: stored key <= new key
  assign key_le   = ($signed(mem_rdata) <= $signed(key_r));
  assign at_last  = ((CW'(idx_r) + CW'(1)) == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_INSERT) begin
            state_nxt = (is_full || is_empty) ? S_FINISH : S_INS_RD;
          end else begin
            state_nxt = is_empty ? S_FINISH : S_REM_RD;
          end
        end
      end
      S_INS_RD:   state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (key_le) begin
          state_nxt = S_FINISH;
        end else if (idx_r == '0) begin
          state_nxt = S_INS_LAST;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_LAST: state_nxt = S_FINISH;
      S_REM_RD:   state_nxt = S_REM_MV;
      S_REM_MV:   state_nxt = at_last ? S_FINISH : S_REM_RD;
      S_FINISH:   state_nxt = slot_free ? S_IDLE : S_FINISH;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs and store writes
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = key_r;
    mem_raddr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_action == ACT_INSERT && is_empty) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = in_value;
        end
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r + AW'(1));
        mem_wdata = key_le ? key_r : mem_rdata;
      end
      S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key_r;
      end
      S_REM_MV: begin
        mem_we    = (idx_r != '0);
        mem_waddr = AW'(idx_r - AW'(1));
        mem_wdata = mem_rdata;
      end
      S_FINISH: begin
        res_valid = slot_free;
      end
      S_INS_RD, S_REM_RD: begin
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    idx_nxt   = idx_r;
    count_nxt = count_r;
    key_nxt   = key_r;
    stat_nxt  = stat_r;
    min_nxt   = min_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt  = in_value;
          stat_nxt = STAT_OK;
          min_nxt  = '0;
          idx_nxt  = '0;
          if (in_action == ACT_INSERT) begin
            if (is_full) begin
              stat_nxt = STAT_FULL;
            end else if (is_empty) begin
              count_nxt = CW'(1);
            end else begin
              idx_nxt = AW'(count_r - CW'(1));
            end
          end else if (is_empty) begin
            stat_nxt = STAT_EMPTY;
          end
        end
      end
      S_INS_CMP: begin
        if (key_le) begin
          count_nxt = count_r + CW'(1);
        end else if (idx_r != '0) begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_INS_LAST: begin
        count_nxt = count_r + CW'(1);
      end
      S_REM_MV: begin
        if (idx_r == '0) begin
          min_nxt = mem_rdata;
        end
        if (at_last) begin
          count_nxt = count_r - CW'(1);
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_INS_RD, S_REM_RD, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
    stat_r <= stat_nxt;
    min_r  <= min_nxt;
  end

  assign res.status    = stat_r;
  assign res.min_value = min_r;
  assign res.occupancy = OCC_W'(count_r);

  // fill count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above capacity");

  // a rejected remove leaves the queue empty and flags it
  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_action == ACT_REMOVE && is_empty)
    |=> (count_r == '0 && stat_r == STAT_EMPTY))
    else $error("remove on empty queue mishandled");

  // a rejected insert leaves the count alone
  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_action == ACT_INSERT && is_full)
    |=> (count_r == CW'(DEPTH) && stat_r == STAT_FULL))
    else $error("insert on full queue mishandled");

  // the front key is captured as the removed minimum
  a_front_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM_MV && idx_r == '0) |=> (min_r == $past(mem_rdata)))
    else $error("removed key not taken from the front");

  // a finished result is handed over only when the output slot is free
  a_finish_leave: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && slot_free) |=> (state_r == S_IDLE))
    else $error("sequencer stuck after handing over result");

endmodule
